// File: src/tni_pkg.sv
package tni_pkg;

    localparam int COORD_BITS_DEF       = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 30;
    localparam int NORMAL_W             = 32;
    localparam int THRESH_W             = 64;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 64'd281474977;

    // one finished result word
    typedef struct packed {
        logic signed [NORMAL_W-1:0] nx;
        logic signed [NORMAL_W-1:0] ny;
        logic signed [NORMAL_W-1:0] nz;
        logic                       inside_res;
        logic                       degen;
    } result_t;

endpackage

// File: src/tni_front.sv
// Edge vectors, cross products, squared normal length, degenerate check.
module tni_front #(
    parameter int COORD_BITS = tni_pkg::COORD_BITS_DEF,
    localparam int CW = 2 * COORD_BITS + 3,
    localparam int SW = 2 * CW + 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [3:0][2:0][COORD_BITS-1:0]  pts,
    input  logic [tni_pkg::THRESH_W-1:0]     thr,
    output logic                             out_valid,
    output logic [SW-1:0]                    s,
    output logic                             degen,
    output logic [2:0][CW-1:0]               mag,
    output logic [12*CW-1:0]                 cu
);
    import tni_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int L2   = CW / 2;
    localparam int HW   = CW - L2;
    localparam int CMPW = (SW > THRESH_W) ? SW : THRESH_W;

    // difference d = pts[DP[d]] - pts[DQ[d]]; points A,B,C,P = 0..3
    localparam int DP [7] = '{1, 2, 3, 3, 2, 3, 0};
    localparam int DQ [7] = '{0, 0, 0, 1, 1, 2, 2};
    // cross x = diff[XA[x]] x diff[XB[x]]; x=0 face normal, 1..3 edges
    localparam int XA [4] = '{0, 2, 3, 5};
    localparam int XB [4] = '{1, 0, 4, 6};

    logic [7:0]               vld_reg;
    logic signed [DW-1:0]     diff_reg [7][3];
    logic signed [2*DW-1:0]   prod_reg [4][6];
    logic [12*CW-1:0]         cu_reg   [6];
    logic [CW-1:0]            mag_reg  [5][3];
    logic [2*HW-1:0]          hh_reg   [3];
    logic [CW-1:0]            hl_reg   [3];
    logic [2*L2-1:0]          ll_reg   [3];
    logic [2*CW-1:0]          sq_reg   [3];
    logic [SW-1:0]            s_reg;
    logic [SW-1:0]            s_out_reg;
    logic                     degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < 7; d++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    diff_reg[d][k] <= $signed(pts[DP[d]][k]) - $signed(pts[DQ[d]][k]);
                end
            end
            for (int x = 0; x < 4; x++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[x][2*k]   <= diff_reg[XA[x]][(k+1)%3] * diff_reg[XB[x]][(k+2)%3];
                    prod_reg[x][2*k+1] <= diff_reg[XA[x]][(k+2)%3] * diff_reg[XB[x]][(k+1)%3];
                end
            end
            for (int x = 0; x < 4; x++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cu_reg[0][(x*3+k)*CW +: CW] <= CW'(prod_reg[x][2*k])
                                                 - CW'(prod_reg[x][2*k+1]);
                end
            end
            for (int i = 1; i < 6; i++)
            begin
                cu_reg[i] <= cu_reg[i-1];
            end
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[0][k] <= cu_reg[0][k*CW+CW-1] ? CW'(-cu_reg[0][k*CW +: CW])
                                                      : cu_reg[0][k*CW +: CW];
            end
            for (int i = 1; i < 5; i++)
            begin
                mag_reg[i] <= mag_reg[i-1];
            end
            // square split into hi/lo halves to keep multipliers narrow
            for (int k = 0; k < 3; k++)
            begin
                hh_reg[k] <= mag_reg[0][k][CW-1:L2] * mag_reg[0][k][CW-1:L2];
                hl_reg[k] <= mag_reg[0][k][CW-1:L2] * mag_reg[0][k][L2-1:0];
                ll_reg[k] <= mag_reg[0][k][L2-1:0] * mag_reg[0][k][L2-1:0];
            end
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= ((2*CW)'(hh_reg[k]) << (2*L2))
                           + ((2*CW)'(hl_reg[k]) << (L2+1))
                           + (2*CW)'(ll_reg[k]);
            end
            s_reg     <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            s_out_reg <= s_reg;
            degen_reg <= CMPW'(s_reg) <= CMPW'(thr);
        end
    end

    assign out_valid = vld_reg[7];
    assign s         = s_out_reg;
    assign degen     = degen_reg;
    assign cu        = cu_reg[5];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = mag_reg[4][k];
        end
    end

endmodule

// File: src/tni_sqrt_cell.sv
// One result bit of the integer square root per cell.
module tni_sqrt_cell #(
    parameter int RW = 82,
    parameter int XW = 164,
    parameter int PW = 766
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [RW:0]   in_rem,
    input  logic [RW-1:0] in_root,
    input  logic [XW-1:0] in_rad,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [RW:0]   out_rem,
    output logic [RW-1:0] out_root,
    output logic [XW-1:0] out_rad,
    output logic [PW-1:0] out_pay
);
    logic [RW+2:0] cur;
    logic [RW+2:0] trial;
    logic          take;
    logic          vld_reg;
    logic [RW:0]   rem_reg;
    logic [RW-1:0] root_reg;
    logic [XW-1:0] rad_reg;
    logic [PW-1:0] pay_reg;

    assign cur   = {in_rem, in_rad[XW-1:XW-2]};
    assign trial = {1'b0, in_root, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= take ? (RW+1)'(cur - trial) : (RW+1)'(cur);
            root_reg <= {in_root[RW-2:0], take};
            rad_reg  <= {in_rad[XW-3:0], 2'b00};
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = vld_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;
    assign out_pay   = pay_reg;

endmodule

// File: src/tni_div_cell.sv
// One quotient bit per cell, three lanes sharing one divisor.
module tni_div_cell #(
    parameter int DVW = 83,
    parameter int QB  = 32,
    parameter int PW  = 613
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DVW-1:0]       in_d,
    input  logic [2:0][DVW-1:0]  in_rem,
    input  logic [2:0][QB-1:0]   in_q,
    input  logic [2:0][QB-1:0]   in_low,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic [DVW-1:0]       out_d,
    output logic [2:0][DVW-1:0]  out_rem,
    output logic [2:0][QB-1:0]   out_q,
    output logic [2:0][QB-1:0]   out_low,
    output logic [PW-1:0]        out_pay
);
    logic [DVW:0]          cur  [3];
    logic [2:0]            take;
    logic                  vld_reg;
    logic [DVW-1:0]        d_reg;
    logic [2:0][DVW-1:0]   rem_reg;
    logic [2:0][QB-1:0]    q_reg;
    logic [2:0][QB-1:0]    low_reg;
    logic [PW-1:0]         pay_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            cur[l]  = {in_rem[l], in_low[l][QB-1]};
            take[l] = cur[l] >= {1'b0, in_d};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= in_d;
            pay_reg <= in_pay;
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[l] <= take[l] ? DVW'(cur[l] - {1'b0, in_d}) : DVW'(cur[l]);
                q_reg[l]   <= {in_q[l][QB-2:0], take[l]};
                low_reg[l] <= {in_low[l][QB-2:0], 1'b0};
            end
        end
    end

    assign out_valid = vld_reg;
    assign out_d     = d_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_low   = low_reg;
    assign out_pay   = pay_reg;

endmodule

// File: src/tni_tail.sv
// Sign and clamp of the normal, edge dot products, same-side decision.
module tni_tail #(
    parameter int COORD_BITS       = tni_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tni_pkg::NORMAL_FRAC_BITS_DEF,
    localparam int CW = 2 * COORD_BITS + 3,
    localparam int QB = NORMAL_FRAC_BITS + 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0][QB-1:0]      in_q,
    input  logic [12*CW:0]          in_pay,
    output logic                    out_valid,
    output tni_pkg::result_t        res
);
    import tni_pkg::*;

    localparam int L2 = CW / 2;
    localparam int HW = CW - L2;
    localparam int NW = NORMAL_W;
    localparam int TW = CW + NW;
    localparam logic [QB-1:0] LIM = QB'(1) << NORMAL_FRAC_BITS;

    logic [3:0]                 vld_reg;
    logic [QB-1:0]              qc      [3];
    logic signed [NW-1:0]       n1_reg  [3];
    logic signed [NW-1:0]       n2_reg  [3];
    logic signed [NW-1:0]       n3_reg  [3];
    logic [9*CW-1:0]            u1_reg;
    logic                       dg1_reg;
    logic                       dg2_reg;
    logic                       dg3_reg;
    logic signed [HW+NW-1:0]    phi_reg [3][3];
    logic signed [L2+NW:0]      plo_reg [3][3];
    logic signed [TW-1:0]       term_reg[3][3];
    logic signed [TW+1:0]       dot     [3];
    logic                       ge_all;
    logic                       le_all;
    result_t                    res_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            qc[l] = (in_q[l] > LIM) ? LIM : in_q[l];
        end
    end

    always_comb
    begin
        ge_all = 1'b1;
        le_all = 1'b1;
        for (int e = 0; e < 3; e++)
        begin
            dot[e] = (TW+2)'(term_reg[e][0]) + (TW+2)'(term_reg[e][1])
                   + (TW+2)'(term_reg[e][2]);
            if (dot[e][TW+1])
            begin
                ge_all = 1'b0;
            end
            else if (dot[e] != '0)
            begin
                le_all = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: signed, clamped normal
            for (int l = 0; l < 3; l++)
            begin
                if (in_pay[12*CW])
                begin
                    n1_reg[l] <= '0;
                end
                else if (in_pay[l*CW+CW-1])
                begin
                    n1_reg[l] <= NW'(0) - NW'(qc[l]);
                end
                else
                begin
                    n1_reg[l] <= NW'(qc[l]);
                end
            end
            u1_reg  <= in_pay[12*CW-1:3*CW];
            dg1_reg <= in_pay[12*CW];
            // stage 2: partial products of edge cross . normal
            for (int e = 0; e < 3; e++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    phi_reg[e][j] <= $signed(u1_reg[(e*3+j)*CW + L2 +: HW]) * n1_reg[j];
                    plo_reg[e][j] <= $signed({1'b0, u1_reg[(e*3+j)*CW +: L2]}) * n1_reg[j];
                end
            end
            n2_reg  <= n1_reg;
            dg2_reg <= dg1_reg;
            // stage 3: recombine halves
            for (int e = 0; e < 3; e++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    term_reg[e][j] <= (TW'(phi_reg[e][j]) <<< L2) + TW'(plo_reg[e][j]);
                end
            end
            n3_reg  <= n2_reg;
            dg3_reg <= dg2_reg;
            // stage 4: decision
            res_reg.nx         <= n3_reg[0];
            res_reg.ny         <= n3_reg[1];
            res_reg.nz         <= n3_reg[2];
            res_reg.inside_res <= dg3_reg || ge_all || le_all;
            res_reg.degen      <= dg3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign res       = res_reg;

endmodule

// File: src/triangle_normal_and_inside_test.sv
// Channel   Direction  Handshake                 Word
// input     in         in_valid / in_stall       vertex_a..c xyz, probe xyz
// result    out        out_valid / out_stall     normal_x/y/z, inside_res, degenerate
// config    in         cfg_valid / cfg_ready     cfg_data (degenerate_threshold)
//
// Throughput: one word per cycle while in_stall is low, fully pipelined.
// Pipeline depth is set by the square-root chain (one root bit per cell) and the
//   divider chain (one quotient bit per cell).
// Reset: rst_n clears all valid bits and loads the default threshold.
// Stalls: an output register plus one skid word; in_stall is the skid-full flag,
//   and the whole pipeline holds while it is set.
module triangle_normal_and_inside_test #(
    parameter int COORD_BITS       = tni_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tni_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [COORD_BITS-1:0]          vertex_a_x,
    input  logic signed [COORD_BITS-1:0]          vertex_a_y,
    input  logic signed [COORD_BITS-1:0]          vertex_a_z,
    input  logic signed [COORD_BITS-1:0]          vertex_b_x,
    input  logic signed [COORD_BITS-1:0]          vertex_b_y,
    input  logic signed [COORD_BITS-1:0]          vertex_b_z,
    input  logic signed [COORD_BITS-1:0]          vertex_c_x,
    input  logic signed [COORD_BITS-1:0]          vertex_c_y,
    input  logic signed [COORD_BITS-1:0]          vertex_c_z,
    input  logic signed [COORD_BITS-1:0]          probe_x,
    input  logic signed [COORD_BITS-1:0]          probe_y,
    input  logic signed [COORD_BITS-1:0]          probe_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [tni_pkg::NORMAL_W-1:0]   normal_x,
    output logic signed [tni_pkg::NORMAL_W-1:0]   normal_y,
    output logic signed [tni_pkg::NORMAL_W-1:0]   normal_z,
    output logic                                  inside_res,
    output logic                                  degenerate,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tni_pkg::THRESH_W-1:0]          cfg_data
);
    import tni_pkg::*;

    localparam int F    = NORMAL_FRAC_BITS;
    localparam int CW   = 2 * COORD_BITS + 3;     // cross product component
    localparam int SW   = 2 * CW + 2;             // squared length
    localparam int XW   = SW + 2 * F;             // radicand
    localparam int RW   = XW / 2;                 // root bits = sqrt cells
    localparam int DVW  = RW + 1;                 // divisor 2*root
    localparam int QB   = F + 2;                  // quotient bits = divider cells
    localparam int NX   = QB + DVW;               // dividend
    localparam int SPW  = 15 * CW + 1;            // {degen, mag, cross words}
    localparam int DPW  = 12 * CW + 1;            // {degen, cross words}
    localparam logic signed [NORMAL_W-1:0] NLIM = NORMAL_W'(1) << F;

    logic                               en;
    logic [THRESH_W-1:0]                thr_reg;
    logic [3:0][2:0][COORD_BITS-1:0]    pts;

    logic                               f_valid;
    logic [SW-1:0]                      f_s;
    logic                               f_degen;
    logic [2:0][CW-1:0]                 f_mag;
    logic [12*CW-1:0]                   f_cu;

    // square root chain
    logic                               sv    [RW+1];
    logic [RW:0]                        srem  [RW+1];
    logic [RW-1:0]                      sroot [RW+1];
    logic [XW-1:0]                      srad  [RW+1];
    logic [SPW-1:0]                     spay  [RW+1];

    // divider setup
    logic [NX-1:0]                      num   [3];
    logic                               pv_reg;
    logic [DVW-1:0]                     pd_reg;
    logic [2:0][DVW-1:0]                prem_reg;
    logic [2:0][QB-1:0]                 plow_reg;
    logic [DPW-1:0]                     ppay_reg;

    // divider chain
    logic                               dv    [QB+1];
    logic [DVW-1:0]                     dd    [QB+1];
    logic [2:0][DVW-1:0]                drem  [QB+1];
    logic [2:0][QB-1:0]                 dq    [QB+1];
    logic [2:0][QB-1:0]                 dlow  [QB+1];
    logic [DPW-1:0]                     dpay  [QB+1];

    logic                               t_valid;
    result_t                            t_res;
    logic                               deliver;

    // output register and skid word
    logic                               ov_reg;
    result_t                            ob_reg;
    logic                               skv_reg;
    result_t                            sk_reg;

    assign en        = !skv_reg;
    assign in_stall  = skv_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    assign pts[0] = {vertex_a_z, vertex_a_y, vertex_a_x};
    assign pts[1] = {vertex_b_z, vertex_b_y, vertex_b_x};
    assign pts[2] = {vertex_c_z, vertex_c_y, vertex_c_x};
    assign pts[3] = {probe_z, probe_y, probe_x};

    tni_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .pts       (pts),
        .thr       (thr_reg),
        .out_valid (f_valid),
        .s         (f_s),
        .degen     (f_degen),
        .mag       (f_mag),
        .cu        (f_cu)
    );

    // root = floor(sqrt(S << 2F)), two radicand bits per cell
    assign sv[0]    = f_valid;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign srad[0]  = XW'(f_s) << (2 * F);
    assign spay[0]  = {f_degen, f_mag, f_cu};

    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        tni_sqrt_cell #(
            .RW (RW),
            .XW (XW),
            .PW (SPW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sv[i]),
            .in_rem    (srem[i]),
            .in_root   (sroot[i]),
            .in_rad    (srad[i]),
            .in_pay    (spay[i]),
            .out_valid (sv[i+1]),
            .out_rem   (srem[i+1]),
            .out_root  (sroot[i+1]),
            .out_rad   (srad[i+1]),
            .out_pay   (spay[i+1])
        );
    end

    // rounded quotient: (|c| * 2^(2F+1) + root) / (2 * root)
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            num[l] = (NX'(spay[RW][12*CW + l*CW +: CW]) << (2 * F + 1))
                   + NX'(sroot[RW]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= sv[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg   <= {sroot[RW], 1'b0};
            ppay_reg <= {spay[RW][SPW-1], spay[RW][12*CW-1:0]};
            for (int l = 0; l < 3; l++)
            begin
                prem_reg[l] <= num[l][NX-1:QB];
                plow_reg[l] <= num[l][QB-1:0];
            end
        end
    end

    assign dv[0]   = pv_reg;
    assign dd[0]   = pd_reg;
    assign drem[0] = prem_reg;
    assign dq[0]   = '0;
    assign dlow[0] = plow_reg;
    assign dpay[0] = ppay_reg;

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        tni_div_cell #(
            .DVW (DVW),
            .QB  (QB),
            .PW  (DPW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv[i]),
            .in_d      (dd[i]),
            .in_rem    (drem[i]),
            .in_q      (dq[i]),
            .in_low    (dlow[i]),
            .in_pay    (dpay[i]),
            .out_valid (dv[i+1]),
            .out_d     (dd[i+1]),
            .out_rem   (drem[i+1]),
            .out_q     (dq[i+1]),
            .out_low   (dlow[i+1]),
            .out_pay   (dpay[i+1])
        );
    end

    tni_tail #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv[QB]),
        .in_q      (dq[QB]),
        .in_pay    (dpay[QB]),
        .out_valid (t_valid),
        .res       (t_res)
    );

    // a finished word leaves the pipeline only while it moves
    assign deliver = en && t_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            skv_reg <= 1'b0;
        end
        else if (!ov_reg || !out_stall)
        begin
            if (skv_reg)
            begin
                ov_reg  <= 1'b1;
                skv_reg <= 1'b0;
            end
            else
            begin
                ov_reg <= deliver;
            end
        end
        else if (deliver)
        begin
            skv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || !out_stall)
        begin
            if (skv_reg)
            begin
                ob_reg <= sk_reg;
            end
            else if (deliver)
            begin
                ob_reg <= t_res;
            end
        end
        else if (deliver)
        begin
            sk_reg <= t_res;
        end
    end

    assign out_valid  = ov_reg;
    assign normal_x   = ob_reg.nx;
    assign normal_y   = ob_reg.ny;
    assign normal_z   = ob_reg.nz;
    assign inside_res = ob_reg.inside_res;
    assign degenerate = ob_reg.degen;

    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skv_reg |-> ov_reg)
        else $error("skid word held with empty output register");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skv_reg) |-> $past(ov_reg && out_stall))
        else $error("skid filled without a stalled output");

    a_degen_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |->
            (inside_res && normal_x == 0 && normal_y == 0 && normal_z == 0))
        else $error("degenerate word with nonzero normal or outside");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (normal_x <= NLIM && normal_x >= -NLIM
                    && normal_y <= NLIM && normal_y >= -NLIM
                    && normal_z <= NLIM && normal_z >= -NLIM))
        else $error("normal component beyond unit magnitude");

endmodule
